// ===== src/dbpd_pkg.sv =====
// Shared constants and types for the dyadic boxcar pulse detector.
package dbpd_pkg;

  localparam int MAX_LEVELS = 6;               // widest bin is 2^MAX_LEVELS samples
  localparam int SLOTS  = MAX_LEVELS + 1;      // one event slot per bin level
  localparam int SUM_W  = 30;  // Q21.8 bin sum
  localparam int SMP_W  = 24;  // Q15.8 input sample
  localparam int SQ_W   = 58;  // square of a non-negative bin sum
  localparam int TSQ_W  = 46;  // square of the base threshold
  localparam int THR_W  = 23;
  localparam int POS_W  = 16;
  localparam int ROW_W  = 12;
  localparam int LVL_W  = 3;
  localparam int SPR_W  = 17;
  localparam int RCNT_W = 13;
  localparam int WID_W  = 7;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_LEVELS    = 2'd1;
  localparam logic [1:0] REG_SAMPLES   = 2'd2;
  localparam logic [1:0] REG_ROWS      = 2'd3;

  localparam logic [SPR_W-1:0]  MAX_SAMPLES = 17'd65536;
  localparam logic [RCNT_W-1:0] MAX_ROWS    = 13'd4096;

  // One sample travelling down the cell chain, with the events found so far.
  typedef struct packed {
    logic                             valid;
    logic                             active;  // still carrying a partial sum
    logic [POS_W-1:0]                 pos;
    logic [ROW_W-1:0]                 row;
    logic [SUM_W-1:0]                 carry;
    logic [LVL_W-1:0]                 levels;
    logic [SLOTS-1:0]                 hits;
    logic [SLOTS-1:0][SUM_W-1:0]      sums;
  } token_t;

endpackage

// ===== src/dbpd_ifs.sv =====
// Stream interfaces for samples in and detection events out.
interface dbpd_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [dbpd_pkg::SMP_W-1:0]      sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface dbpd_event_if;
  logic                                   valid;
  logic                                   ready;
  logic [dbpd_pkg::ROW_W-1:0]             dm_index;
  logic [dbpd_pkg::POS_W-1:0]             start_time;
  logic [dbpd_pkg::WID_W-1:0]             bin_width;
  logic signed [dbpd_pkg::SUM_W-1:0]      event_power;
  logic                                   last_event;

  modport source (output valid, output dm_index, output start_time, output bin_width,
                  output event_power, output last_event, input ready);
  modport sink   (input valid, input dm_index, input start_time, input bin_width,
                  input event_power, input last_event, output ready);
endinterface

// ===== src/dyadic_boxcar_pulse_detector.sv =====
// Top level of the dyadic boxcar pulse detector.
// A sample's token passes the a_tok and b_tok registers of each cell, then the emitter's registers.
// Throughput: one sample per cycle while the event port keeps up; a sample with several
//   events stalls the chain while the single event output port sends them in turn.
// Reset: synchronous; clears the counters, pending sums and all valid bits and loads the
//   register defaults (threshold 0, 6 levels, 65536 samples per row, 4096 rows).
module dyadic_boxcar_pulse_detector (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [dbpd_pkg::THR_W-1:0]  cfg_data,
  dbpd_sample_if.sink                 samples,
  dbpd_event_if.source                events
);
  import dbpd_pkg::*;

  // configuration registers
  logic [THR_W-1:0]  base_threshold;
  logic [LVL_W-1:0]  bin_levels;
  logic [SPR_W-1:0]  samples_per_row;
  logic [RCNT_W-1:0] row_count;
  logic [TSQ_W-1:0]  tsq;  // threshold squared, registered from base_threshold

  // stream position
  logic [POS_W-1:0]  time_counter;
  logic [ROW_W-1:0]  row_counter;

  logic [LVL_W-1:0]  levels_eff;
  logic [SPR_W-1:0]  spr_eff, limit, pos_inc;
  logic [RCNT_W-1:0] rows_eff, row_inc;
  logic              adv, accept;
  token_t            head;
  token_t            links [MAX_LEVELS+2];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_threshold  <= '0;
      bin_levels      <= 3'd6;
      samples_per_row <= MAX_SAMPLES;
      row_count       <= MAX_ROWS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD: base_threshold  <= cfg_data;
        REG_LEVELS:    bin_levels      <= cfg_data[LVL_W-1:0];
        REG_SAMPLES:   samples_per_row <= cfg_data[SPR_W-1:0];
        REG_ROWS:      row_count       <= cfg_data[RCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tsq <= TSQ_W'(base_threshold) * TSQ_W'(base_threshold);
  end

  // clamp registers into their working ranges
  assign levels_eff = (bin_levels > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS) : bin_levels;
  assign spr_eff    = (samples_per_row == '0) ? SPR_W'(1) :
                      (samples_per_row > MAX_SAMPLES) ? MAX_SAMPLES : samples_per_row;
  assign rows_eff   = (row_count == '0) ? RCNT_W'(1) :
                      (row_count > MAX_ROWS) ? MAX_ROWS : row_count;
  // end of the last whole block in the row
  assign limit      = spr_eff & ~((SPR_W'(1) << levels_eff) - SPR_W'(1));

  assign pos_inc = {1'b0, time_counter} + SPR_W'(1);
  assign row_inc = {1'b0, row_counter} + RCNT_W'(1);

  // whole chain moves together; it stalls only when the emitter cannot take the tail
  assign samples.ready = adv;
  assign accept        = samples.valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_counter <= '0;
      row_counter  <= '0;
    end else if (accept) begin
      if (pos_inc >= spr_eff) begin
        time_counter <= '0;
        row_counter  <= (row_inc >= rows_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        time_counter <= pos_inc[POS_W-1:0];
      end
    end
  end

  // samples past the last whole block ride the chain inactive and yield nothing
  always_comb begin
    head        = '0;
    head.valid  = samples.valid;
    head.active = {1'b0, time_counter} < limit;
    head.pos    = time_counter;
    head.row    = row_counter;
    head.carry  = SUM_W'(samples.sample);
    head.levels = levels_eff;
  end

  assign links[0] = head;

  // cell n tests sums of width 2^n; every cell but cell 0 owns the pending sum of width 2^(n-1)
  for (genvar n = 0; n <= MAX_LEVELS; n++) begin : g_cell
    dbpd_cell #(
      .LEVEL (n)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tsq     (tsq),
      .tok_in  (links[n]),
      .tok_out (links[n+1])
    );
  end

  dbpd_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .tail   (links[MAX_LEVELS+1]),
    .adv    (adv),
    .events (events)
  );

  // a stalled chain keeps its tail transaction intact
  a_tail_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(links[MAX_LEVELS+1]))
    else $error("tail token changed while chain stalled");

  a_width_onehot: assert property (@(posedge clk) disable iff (rst)
    events.valid |-> $onehot(events.bin_width))
    else $error("bin width not a power of two");

  a_power_nonneg: assert property (@(posedge clk) disable iff (rst)
    events.valid |-> !events.event_power[SUM_W-1])
    else $error("negative sum passed threshold");

  a_start_aligned: assert property (@(posedge clk) disable iff (rst)
    events.valid |-> ((events.start_time & (POS_W'(events.bin_width) - POS_W'(1))) == '0))
    else $error("start time not aligned to bin width");

endmodule

// ===== src/dbpd_cell.sv =====
// One level of the boxcar chain: pair-sum, square, threshold test.
module dbpd_cell #(
  parameter int LEVEL = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic [dbpd_pkg::TSQ_W-1:0] tsq,
  input  dbpd_pkg::token_t           tok_in,
  output dbpd_pkg::token_t           tok_out
);
  import dbpd_pkg::*;

  token_t           a_tok, a_next, b_tok;
  logic             a_use, b_use, use_next, live, hit;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-2:0] mag;
  logic [SQ_W-1:0]  b_sq, thr;

  assign live = tok_in.valid && tok_in.active && (LVL_W'(LEVEL) <= tok_in.levels);

  if (LEVEL == 0) begin : g_head
    assign use_next = live;
    assign sum      = tok_in.carry;
  end else begin : g_pair
    logic             store;
    logic [SUM_W-1:0] pending;  // left-hand sum of width 2^(LEVEL-1)

    assign use_next = live && tok_in.pos[LEVEL-1];
    assign store    = live && !tok_in.pos[LEVEL-1];
    assign sum      = pending + tok_in.carry;

    always_ff @(posedge clk) begin
      if (rst) begin
        pending <= '0;
      end else if (adv && store) begin
        pending <= tok_in.carry;
      end
    end
  end

  always_comb begin
    a_next        = tok_in;
    a_next.carry  = sum;
    a_next.active = use_next;
  end

  assign mag = a_tok.carry[SUM_W-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tok.valid <= 1'b0;
      b_tok.valid <= 1'b0;
    end else if (adv) begin
      a_tok <= a_next;
      b_tok <= a_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_use <= use_next;
      b_use <= a_use;
      b_sq  <= SQ_W'(mag) * SQ_W'(mag);
    end
  end

  // sum >= T*sqrt(2^LEVEL)  <=>  sum >= 0 and sum^2 >= T^2 * 2^LEVEL
  assign thr = SQ_W'(tsq) << LEVEL;
  assign hit = b_tok.valid && b_use && !b_tok.carry[SUM_W-1] && (b_sq >= thr);

  always_comb begin
    tok_out              = b_tok;
    tok_out.hits[LEVEL]  = hit;
    tok_out.sums[LEVEL]  = b_tok.carry;
  end

endmodule

// ===== src/dbpd_emit.sv =====
// Event serializer: emits one sample's events narrowest first.
module dbpd_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  dbpd_pkg::token_t      tail,
  output logic                  adv,
  dbpd_event_if.source          events
);
  import dbpd_pkg::*;

  logic [SLOTS-1:0]            hits, rest;
  logic [SLOTS-1:0][SUM_W-1:0] sums;
  logic [POS_W-1:0]            pos;
  logic [ROW_W-1:0]            row;
  logic [LVL_W-1:0]            k;
  logic                        single, take;

  always_comb begin
    k = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hits[i]) begin
        k = LVL_W'(i);
      end
    end
  end

  assign rest   = hits & (hits - SLOTS'(1));
  assign single = (rest == '0);
  assign take   = (hits == '0) || (events.ready && single);
  assign adv    = take || !tail.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hits <= '0;
    end else if (take) begin
      hits <= tail.valid ? tail.hits : '0;
    end else if (events.ready) begin
      hits <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sums <= tail.sums;
      pos  <= tail.pos;
      row  <= tail.row;
    end
  end

  assign events.valid       = (hits != '0);
  assign events.dm_index    = row;
  assign events.start_time  = pos & ~((POS_W'(1) << k) - POS_W'(1));
  assign events.bin_width   = WID_W'(1) << k;
  assign events.event_power = sums[k];
  assign events.last_event  = single;

endmodule

// ===== verif/dyadic_boxcar_pulse_detector_tb.sv =====
// Self-checking testbench for the dyadic boxcar pulse detector: directed table, then random runs.
`timescale 1ns / 100ps

module dyadic_boxcar_pulse_detector_tb;
  import dbpd_pkg::*;

  // Idle cycles after the last event before config writes and at the end:
  // the full pipeline depth plus margin, since a sample may yield no event.
  localparam int SETTLE      = 2 * (SLOTS - 1) + 2 + 10;
  localparam int STALL_LIMIT = 2000;  // cycles with no transaction on either side
  localparam int RAND_ITEMS  = 230;
  localparam int STIM_ROWS   = 30;

  // One detection event, laid out like the event channel payload.
  typedef struct packed {
    logic [ROW_W-1:0]        dm_index;
    logic [POS_W-1:0]        start_time;
    logic [WID_W-1:0]        bin_width;
    logic signed [SUM_W-1:0] event_power;
    logic                    last_event;
  } det_event_t;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_e;
  // Where the expected events of a sample row come from.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_chk_e;
  typedef enum logic [1:0] {RX_OPEN, RX_PATTERN, RX_CHOPPY} rx_mode_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       reg_idx;   // unused on sample rows
    logic [SMP_W-1:0] value;     // register data or sample
    row_chk_e         chk;
    det_event_t       ev;        // typed-in event for CHK_ONE rows
  } stim_row_t;

  localparam det_event_t NO_EV = '0;

  // Directed part. Walks from reset defaults (threshold 0, 6 levels, long rows)
  // through threshold extremes, a row shortened under the running counter,
  // row wrap, a config change inside a block, the trailing partial block,
  // and out-of-range register values.
  stim_row_t stim_tab [STIM_ROWS] = '{
    '{ROW_SMP, '0, 24'h7FFFFF, CHK_ONE, '{12'd0, 16'd0, 7'd1, 30'd8388607, 1'b1}},
    '{ROW_SMP, '0, 24'h800000, CHK_NONE, NO_EV},   // negative sums never pass
    '{ROW_SMP, '0, 24'h000000, CHK_ONE, '{12'd0, 16'd2, 7'd1, 30'd0, 1'b1}},
    '{ROW_SMP, '0, 24'h000100, CHK_MODEL, NO_EV},
    '{ROW_CFG, REG_THRESHOLD, 24'h7FFFFF, CHK_NONE, NO_EV},
    // sum equal to the threshold passes
    '{ROW_SMP, '0, 24'h7FFFFF, CHK_ONE, '{12'd0, 16'd4, 7'd1, 30'd8388607, 1'b1}},
    '{ROW_SMP, '0, 24'h7FFFFE, CHK_MODEL, NO_EV},
    '{ROW_SMP, '0, 24'hFFFFFF, CHK_NONE, NO_EV},
    '{ROW_CFG, REG_LEVELS, 24'd0, CHK_NONE, NO_EV},
    '{ROW_CFG, REG_SAMPLES, 24'd3, CHK_NONE, NO_EV},
    '{ROW_CFG, REG_ROWS, 24'd2, CHK_NONE, NO_EV},
    '{ROW_CFG, REG_THRESHOLD, 24'd0, CHK_NONE, NO_EV},
    // counter already past the shortened row: silent, row ends here
    '{ROW_SMP, '0, 24'd100, CHK_NONE, NO_EV},
    '{ROW_SMP, '0, 24'd5, CHK_ONE, '{12'd1, 16'd0, 7'd1, 30'd5, 1'b1}},
    '{ROW_SMP, '0, 24'h800000, CHK_NONE, NO_EV},
    '{ROW_SMP, '0, 24'd0, CHK_ONE, '{12'd1, 16'd2, 7'd1, 30'd0, 1'b1}},
    // row counter wrapped back to zero
    '{ROW_SMP, '0, 24'd7, CHK_ONE, '{12'd0, 16'd0, 7'd1, 30'd7, 1'b1}},
    '{ROW_CFG, REG_LEVELS, 24'd1, CHK_NONE, NO_EV},
    // pairs with a pending sum left from the earlier 6-level setting
    '{ROW_SMP, '0, 24'd9, CHK_MODEL, NO_EV},
    // trailing partial block: no events
    '{ROW_SMP, '0, 24'd11, CHK_NONE, NO_EV},
    '{ROW_CFG, REG_SAMPLES, 24'd0, CHK_NONE, NO_EV},
    '{ROW_CFG, REG_ROWS, 24'd0, CHK_NONE, NO_EV},
    '{ROW_CFG, REG_LEVELS, 24'd0, CHK_NONE, NO_EV},
    '{ROW_SMP, '0, 24'd3, CHK_ONE, '{12'd1, 16'd0, 7'd1, 30'd3, 1'b1}},
    '{ROW_SMP, '0, 24'd4, CHK_ONE, '{12'd0, 16'd0, 7'd1, 30'd4, 1'b1}},
    '{ROW_CFG, REG_SAMPLES, 24'h01FFFF, CHK_NONE, NO_EV},
    '{ROW_CFG, REG_ROWS, 24'h001FFF, CHK_NONE, NO_EV},
    '{ROW_CFG, REG_LEVELS, 24'd7, CHK_NONE, NO_EV},
    '{ROW_SMP, '0, 24'h400000, CHK_MODEL, NO_EV},
    '{ROW_SMP, '0, 24'h3FFFFF, CHK_MODEL, NO_EV}
  };

  logic clk = 1'b0;
  logic rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [THR_W-1:0]   cfg_data;

  dbpd_sample_if sample_ch ();
  dbpd_event_if  event_ch ();

  dyadic_boxcar_pulse_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (sample_ch),
    .events    (event_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: register copies, pending pairwise sums, counters.
  logic [THR_W-1:0]  thr;
  logic [LVL_W-1:0]  lvl_reg;
  logic [SPR_W-1:0]  spr_reg;
  logic [RCNT_W-1:0] rows_reg;
  longint            acc_sum [SLOTS];
  int                t_idx;
  int                row_idx;

  det_event_t events_due [$];    // expected events, oldest first
  det_event_t fresh_events [$];  // events of the sample just taken
  det_event_t due_head;
  bit         failed;
  int         events_seen;
  int         burst_left;
  int         idle_cycles;
  int         rx_tick;
  rx_mode_e   rx_mode;
  logic [15:0] rx_pattern;

  // s >= thr*sqrt(2^lvl), done exactly on squares; negative sums fail.
  function automatic bit clears_thr(input longint s, input int lvl);
    longint unsigned t_sq;
    longint unsigned s_sq;
    if (s < 0) return 1'b0;
    t_sq = 64'(thr);
    t_sq = t_sq * t_sq;
    s_sq = s;
    s_sq = s_sq * s_sq;
    return s_sq >= (t_sq << lvl);
  endfunction

  task automatic note_event(input int start, input int lvl, input longint s);
    det_event_t hit;
    hit.dm_index    = row_idx[ROW_W-1:0];
    hit.start_time  = start[POS_W-1:0];
    hit.bin_width   = WID_W'(1 << lvl);
    hit.event_power = s[SUM_W-1:0];
    hit.last_event  = 1'b0;
    fresh_events.push_back(hit);
  endtask

  // Advance the predictor by one sample; its events land in fresh_events,
  // narrowest first.
  task automatic boxcar_detect(input logic signed [SMP_W-1:0] smp);
    int     lv;
    int     spr;
    int     rows;
    int     lim;
    int     pos;
    int     n;
    longint carry;
    bit     fold;
    lv   = (lvl_reg > 6) ? 6 : lvl_reg;
    spr  = (spr_reg == 0) ? 1 : (spr_reg > MAX_SAMPLES) ? MAX_SAMPLES : spr_reg;
    rows = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    lim  = (spr / (1 << lv)) * (1 << lv);
    pos  = t_idx;
    fresh_events.delete();
    if (pos < lim) begin
      carry = smp;
      if (clears_thr(carry, 0)) note_event(pos, 0, carry);
      fold = 1'b1;
      for (n = 1; n <= lv && fold; n++) begin
        if (((pos >> (n - 1)) & 1) == 0) begin
          // left half of the next width: park it and stop
          acc_sum[n-1] = carry;
          fold = 1'b0;
        end else begin
          carry = acc_sum[n-1] + carry;
          if (clears_thr(carry, n)) note_event(pos & ~((1 << n) - 1), n, carry);
        end
      end
    end
    if (fresh_events.size() > 0) fresh_events[fresh_events.size()-1].last_event = 1'b1;
    if (pos + 1 >= spr) begin
      t_idx   = 0;
      row_idx = (row_idx + 1 >= rows) ? 0 : row_idx + 1;
    end else begin
      t_idx = pos + 1;
    end
  endtask

  // Register write; the block is idle whenever this is called.
  task automatic write_reg(input logic [1:0] idx, input logic [THR_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD: thr      = val;
      REG_LEVELS:    lvl_reg  = val[LVL_W-1:0];
      REG_SAMPLES:   spr_reg  = val[SPR_W-1:0];
      REG_ROWS:      rows_reg = val[RCNT_W-1:0];
      default: ;
    endcase
  endtask

  // One sample transaction. Bursts of random length, random gaps between.
  // Valid gets one assignment per time step: lowered only when a gap starts.
  task automatic push_sample(input logic signed [SMP_W-1:0] smp, input bit predicted);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        sample_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= smp;
    do @(posedge clk); while (!sample_ch.ready);
    burst_left--;
    boxcar_detect(smp);
    if (predicted) foreach (fresh_events[i]) events_due.push_back(fresh_events[i]);
  endtask

  // Stop sending, drain all expected events, then let the pipeline empty.
  task automatic quiesce();
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want_v,
                             input logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      failed = 1'b1;
    end
  endtask

  // Event checker and receiver. Every accepted event transaction is matched
  // against the oldest expectation. Ready follows a randomly picked mode:
  // always open, a rotating 16-bit pattern, or random chop.
  always @(posedge clk) begin
    if (!rst && event_ch.valid && event_ch.ready) begin
      events_seen++;
      if (events_due.size() == 0) begin
        $display("%0t: unexpected event, dm %0d start %0d width %0d power %0d last %0d",
                 $time, event_ch.dm_index, event_ch.start_time, event_ch.bin_width,
                 event_ch.event_power, event_ch.last_event);
        failed = 1'b1;
      end else begin
        due_head = events_due.pop_front();
        check_field("dm_index", due_head.dm_index, event_ch.dm_index);
        check_field("start_time", due_head.start_time, event_ch.start_time);
        check_field("bin_width", due_head.bin_width, event_ch.bin_width);
        check_field("event_power", due_head.event_power, event_ch.event_power);
        check_field("last_event", due_head.last_event, event_ch.last_event);
      end
    end
    rx_tick++;
    if (rx_tick % 97 == 0) begin
      rx_mode    = rx_mode_e'($urandom_range(0, 2));
      rx_pattern = 16'($urandom) | 16'h0001;  // never stalls a full rotation
    end
    case (rx_mode)
      RX_OPEN:    event_ch.ready <= 1'b1;
      RX_PATTERN: event_ch.ready <= rx_pattern[rx_tick % 16];
      default:    event_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog: too long with no transaction on either channel means a hang.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (event_ch.valid && event_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("dyadic_boxcar_pulse_detector test failed");
      $finish;
    end
  end

  initial begin
    int                      n;
    int                      smp_sent;
    int                      lv;
    int unsigned             big;
    logic [THR_W-1:0]        v;
    logic signed [SMP_W-1:0] s;

    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = REG_THRESHOLD;
    cfg_data         = '0;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    event_ch.ready   = 1'b0;
    rx_mode          = RX_OPEN;
    rx_pattern       = 16'hFFFF;

    // predictor at its reset state
    thr      = '0;
    lvl_reg  = 3'd6;
    spr_reg  = MAX_SAMPLES;
    rows_reg = MAX_ROWS;
    foreach (acc_sum[i]) acc_sum[i] = 0;
    t_idx    = 0;
    row_idx  = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_CFG) begin
        quiesce();
        write_reg(stim_tab[i].reg_idx, stim_tab[i].value[THR_W-1:0]);
      end else begin
        push_sample(stim_tab[i].value, stim_tab[i].chk == CHK_MODEL);
        if (stim_tab[i].chk == CHK_ONE) events_due.push_back(stim_tab[i].ev);
      end
    end

    // Random phases: fresh settings while idle, then a batch of samples.
    // Counters and pending sums carry across phases on purpose.
    smp_sent = 0;
    while (smp_sent < RAND_ITEMS) begin
      quiesce();
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = 23'h7FFFFF;
        2:       v = THR_W'($urandom);
        default: v = THR_W'($urandom_range(1, 3000));
      endcase
      write_reg(REG_THRESHOLD, v);
      lv = $urandom_range(0, 7);  // 7 behaves as 6
      write_reg(REG_LEVELS, THR_W'(lv));
      case ($urandom_range(0, 7))
        0:       v = '0;
        1:       v = THR_W'(1);
        2:       v = THR_W'(MAX_SAMPLES);
        3:       v = THR_W'($urandom_range(65537, 131071));
        4:       v = THR_W'($urandom_range(2, 40));
        // a few whole blocks, sometimes with a partial tail
        default: v = THR_W'((1 << (lv > 6 ? 6 : lv)) * $urandom_range(1, 3) +
                            $urandom_range(0, 2));
      endcase
      write_reg(REG_SAMPLES, v);
      case ($urandom_range(0, 4))
        0:       v = '0;
        1:       v = THR_W'(MAX_ROWS);
        2:       v = THR_W'($urandom_range(4097, 8191));
        default: v = THR_W'($urandom_range(1, 5));
      endcase
      write_reg(REG_ROWS, v);

      n = $urandom_range(12, 40);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0:       s = SMP_W'($urandom);
          1:       s = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
          2, 3:    s = 24'($urandom_range(0, 4095)) ^ 24'hFFFFFF;  // small negative
          default: begin
            // around the threshold so bins fall on both sides of it
            big = $urandom_range(0, 2 * thr + 64);
            s   = (big > 32'h7FFFFF) ? 24'h7FFFFF : SMP_W'(big);
          end
        endcase
        push_sample(s, 1'b1);
      end
      smp_sent += n;
    end

    quiesce();
    if (!failed && events_due.size() == 0)
      $display("dyadic_boxcar_pulse_detector test passed");
    else
      $display("dyadic_boxcar_pulse_detector test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dbpd_pkg.sv
src/dbpd_ifs.sv
src/dbpd_cell.sv
src/dbpd_emit.sv
src/dyadic_boxcar_pulse_detector.sv
verif/dyadic_boxcar_pulse_detector_tb.sv
